// File: design/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared widths, codes and types of the section address translator.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int SECT_NUM = 64;
    localparam int IDX_W    = (SECT_NUM > 1) ? $clog2(SECT_NUM) : 1;
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 7;
    localparam int EIDX_W   = 6;
    // Width in which table slots, entry indexes and the count are compared.
    localparam int CMP_W    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    localparam logic [1:0] CFG_HEADERS_SIZE  = 2'd0;
    localparam logic [1:0] CFG_FILE_SIZE     = 2'd1;
    localparam logic [1:0] CFG_SECTION_COUNT = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_XLATE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] vsize;
        logic [ADDR_W-1:0] raw_off;
        logic [ADDR_W-1:0] raw_size;
    } sat_entry_t;

    // Query token that walks the row of cells.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] raw_off;
        logic [ADDR_W-1:0] raw_size;
    } sat_tok_t;

endpackage

// File: design/sat_cell.sv
// ----------------------------------------------------------------------------
// sat_cell
// One section table slot: holds an entry and tests the passing query token.
// ----------------------------------------------------------------------------
module sat_cell
    import sat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   cell_id,
    input  logic [CNT_W-1:0]   section_count,
    input  logic               wr_en,
    input  logic [EIDX_W-1:0]  wr_index,
    input  sat_entry_t         wr_entry,
    input  logic               tok_in_valid,
    input  sat_tok_t           tok_in,
    output logic               tok_out_valid,
    output sat_tok_t           tok_out
);

    sat_entry_t         entry_reg;
    logic               tok_valid_reg;
    sat_tok_t           tok_reg;
    sat_tok_t           tok_next;
    logic [CMP_W-1:0]   id_ext;
    logic               active;
    logic               wr_hit;
    logic [ADDR_W-1:0]  size_max;
    logic [ADDR_W:0]    span_end;
    logic               hit;

    assign id_ext = CMP_W'(cell_id);
    assign active = id_ext < CMP_W'(section_count);
    assign wr_hit = wr_en && (CMP_W'(wr_index) == id_ext);

    assign size_max = (entry_reg.vsize > entry_reg.raw_size) ? entry_reg.vsize
                                                             : entry_reg.raw_size;
    assign span_end = {1'b0, entry_reg.start} + {1'b0, size_max};
    assign hit      = (tok_in.addr >= entry_reg.start) && ({1'b0, tok_in.addr} < span_end);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found && active && hit)
        begin
            tok_next.found    = 1'b1;
            tok_next.idx      = cell_id;
            tok_next.start    = entry_reg.start;
            tok_next.raw_off  = entry_reg.raw_off;
            tok_next.raw_size = entry_reg.raw_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            entry_reg <= wr_entry;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// File: design/sat_finish.sv
// ----------------------------------------------------------------------------
// sat_finish
// Resolves the token leaving the row into a file offset, in two stages.
// ----------------------------------------------------------------------------
module sat_finish
    import sat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  sat_tok_t           tok,
    input  logic [ADDR_W-1:0]  headers_size,
    input  logic [ADDR_W-1:0]  file_size,
    output logic               res_valid,
    output logic               res_offset_valid,
    output logic [ADDR_W-1:0]  res_file_offset,
    output logic               res_found,
    output logic [IDX_W-1:0]   res_idx
);

    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               s1_hdr_hit_reg;
    logic               s1_found_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_delta_ok_reg;
    logic [ADDR_W-1:0]  s1_delta_reg;
    logic [ADDR_W-1:0]  s1_raw_off_reg;

    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [ADDR_W-1:0]  out_offset_reg;
    logic               out_found_reg;
    logic [IDX_W-1:0]   out_idx_reg;

    logic [ADDR_W-1:0]  delta;
    logic [ADDR_W:0]    sect_off;
    logic               sect_ok;

    // The token only carries a section when the address is at or above its start.
    assign delta    = tok.addr - tok.start;
    assign sect_off = {1'b0, s1_raw_off_reg} + {1'b0, s1_delta_reg};
    assign sect_ok  = s1_delta_ok_reg && !sect_off[ADDR_W]
                      && (sect_off[ADDR_W-1:0] < file_size);

    always_ff @(posedge clk)
    begin
        s1_addr_reg     <= tok.addr;
        s1_hdr_hit_reg  <= (tok.addr < headers_size) && (tok.addr < file_size);
        s1_found_reg    <= tok.found;
        s1_idx_reg      <= tok.found ? tok.idx : '0;
        s1_delta_ok_reg <= tok.found && (delta < tok.raw_size);
        s1_delta_reg    <= delta;
        s1_raw_off_reg  <= tok.raw_off;

        out_found_reg   <= s1_found_reg;
        out_idx_reg     <= s1_idx_reg;
        if (s1_hdr_hit_reg)
        begin
            out_ok_reg     <= 1'b1;
            out_offset_reg <= s1_addr_reg;
        end
        else if (sect_ok)
        begin
            out_ok_reg     <= 1'b1;
            out_offset_reg <= sect_off[ADDR_W-1:0];
        end
        else
        begin
            out_ok_reg     <= 1'b0;
            out_offset_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= tok_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign res_valid        = out_valid_reg;
    assign res_offset_valid = out_ok_reg;
    assign res_file_offset  = out_offset_reg;
    assign res_found        = out_found_reg;
    assign res_idx          = out_idx_reg;

endmodule

// File: design/section_address_translator.sv
// ----------------------------------------------------------------------------
// section_address_translator
// Section table with virtual address to file offset translation.
// ----------------------------------------------------------------------------
// A write item (action 0) stores one section entry in the cell of its slot and
// yields an all-zero result on the cycle after it is taken; busy stays low.
// A translate item (action 1) sends the query along the row of 64 table cells,
// one cell per cycle, then through two resolve stages; its result comes straight
// from the registers of the second stage, and busy is high until that
// result cycle ends. Results show for one cycle under done and cannot be held
// off, so the receiver must take every result when done is high. Slots must be
// written before section_count covers them.
module section_address_translator
    import sat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [EIDX_W-1:0]  entry_index,
    input  logic [31:0]        section_start,
    input  logic [31:0]        section_virtual_size,
    input  logic [31:0]        section_raw_offset,
    input  logic [31:0]        section_raw_size,
    input  logic [31:0]        query_address,
    output logic               done,
    output logic               offset_valid,
    output logic [31:0]        file_offset,
    output logic               section_found,
    output logic [EIDX_W-1:0]  section_index
);

    logic [ADDR_W-1:0]  headers_size_reg;
    logic [ADDR_W-1:0]  file_size_reg;
    logic [CNT_W-1:0]   section_count_reg;
    logic               busy_reg;
    logic               busy_next;
    logic               wdone_reg;

    logic               accept;
    logic               wr_en;
    sat_entry_t         wr_entry;

    logic               tok_valid [SECT_NUM+1];
    sat_tok_t           tok       [SECT_NUM+1];

    logic               res_valid;
    logic               res_offset_valid;
    logic [ADDR_W-1:0]  res_file_offset;
    logic               res_found;
    logic [IDX_W-1:0]   res_idx;
    logic [CMP_W-1:0]   res_idx_ext;

    assign accept = start && !busy_reg;
    assign wr_en  = accept && (action == ACT_WRITE);

    assign wr_entry.start    = section_start;
    assign wr_entry.vsize    = section_virtual_size;
    assign wr_entry.raw_off  = section_raw_offset;
    assign wr_entry.raw_size = section_raw_size;

    assign tok_valid[0]    = accept && (action == ACT_XLATE);
    assign tok[0].addr     = query_address;
    assign tok[0].found    = 1'b0;
    assign tok[0].idx      = '0;
    assign tok[0].start    = '0;
    assign tok[0].raw_off  = '0;
    assign tok[0].raw_size = '0;

    for (genvar i = 0; i < SECT_NUM; i++)
    begin : g_cell
        sat_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_id       (IDX_W'(i)),
            .section_count (section_count_reg),
            .wr_en         (wr_en),
            .wr_index      (entry_index),
            .wr_entry      (wr_entry),
            .tok_in_valid  (tok_valid[i]),
            .tok_in        (tok[i]),
            .tok_out_valid (tok_valid[i+1]),
            .tok_out       (tok[i+1])
        );
    end

    sat_finish u_finish (
        .clk              (clk),
        .rst_n            (rst_n),
        .tok_valid        (tok_valid[SECT_NUM]),
        .tok              (tok[SECT_NUM]),
        .headers_size     (headers_size_reg),
        .file_size        (file_size_reg),
        .res_valid        (res_valid),
        .res_offset_valid (res_offset_valid),
        .res_file_offset  (res_file_offset),
        .res_found        (res_found),
        .res_idx          (res_idx)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (tok_valid[0])
        begin
            busy_next = 1'b1;
        end
        else if (res_valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            headers_size_reg  <= '0;
            file_size_reg     <= '0;
            section_count_reg <= '0;
            busy_reg          <= 1'b0;
            wdone_reg         <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            wdone_reg <= wr_en;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADERS_SIZE:  headers_size_reg  <= cfg_data;
                    CFG_FILE_SIZE:     file_size_reg     <= cfg_data;
                    CFG_SECTION_COUNT: section_count_reg <= cfg_data[CNT_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // A write result is all zero; it never meets a translate result.
    assign res_idx_ext   = CMP_W'(res_idx);
    assign busy          = busy_reg;
    assign done          = wdone_reg || res_valid;
    assign offset_valid  = res_valid && res_offset_valid;
    assign file_offset   = res_valid ? res_file_offset : '0;
    assign section_found = res_valid && res_found;
    assign section_index = res_valid ? res_idx_ext[EIDX_W-1:0] : '0;

endmodule

// File: bench/section_address_translator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// section_address_translator_tb
// Drives table writes and address translations into the section address
// translator and checks every result against an in-bench translation model.
// A short directed table with hand-worked results comes first, then random
// table layouts, register settings and queries aimed at section boundaries.
// ----------------------------------------------------------------------------
module section_address_translator_tb;
    import sat_pkg::*;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 1000;
    localparam int         DRAIN_WAIT  = 70;
    localparam int         RAND_PHASES = 11;
    localparam int         PHASE_ITEMS = 90;

    typedef struct packed {
        logic              act;
        logic [EIDX_W-1:0] slot;
        sat_entry_t        ent;
        logic [31:0]       addr;
    } request_t;

    typedef struct packed {
        logic              valid;
        logic [31:0]       offset;
        logic              found;
        logic [EIDX_W-1:0] idx;
    } outcome_t;

    typedef enum logic { ROW_REG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        request_t    req;
        bit          fixed;
        outcome_t    want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;
    logic              start;
    logic              busy;
    logic              action;
    logic [EIDX_W-1:0] entry_index;
    logic [31:0]       section_start;
    logic [31:0]       section_virtual_size;
    logic [31:0]       section_raw_offset;
    logic [31:0]       section_raw_size;
    logic [31:0]       query_address;
    logic              done;
    logic              offset_valid;
    logic [31:0]       file_offset;
    logic              section_found;
    logic [EIDX_W-1:0] section_index;

    // Shadow of the block's registers and section table.
    logic [31:0]      hdr_size;
    logic [31:0]      file_len;
    logic [CNT_W-1:0] sect_count;
    sat_entry_t       sect_tab [SECT_NUM];

    outcome_t  pending_results [$];
    stim_row_t plan [$];
    int        fail_count;
    int        idle_run;
    outcome_t  seen;
    outcome_t  oldest;

    section_address_translator i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .start                (start),
        .busy                 (busy),
        .action               (action),
        .entry_index          (entry_index),
        .section_start        (section_start),
        .section_virtual_size (section_virtual_size),
        .section_raw_offset   (section_raw_offset),
        .section_raw_size     (section_raw_size),
        .query_address        (query_address),
        .done                 (done),
        .offset_valid         (offset_valid),
        .file_offset          (file_offset),
        .section_found        (section_found),
        .section_index        (section_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // First section whose span holds the address, then header window or
    // section mapping for the offset.
    function automatic outcome_t translate_address(input logic [31:0] addr);
        outcome_t    res;
        int          lim;
        sat_entry_t  e;
        logic [31:0] span;
        logic [32:0] top;
        logic [31:0] delta;
        logic [32:0] off;
        res = '0;
        lim = (int'(sect_count) > SECT_NUM) ? SECT_NUM : int'(sect_count);
        for (int s = 0; s < lim; s++)
        begin
            e = sect_tab[s];
            span = (e.vsize > e.raw_size) ? e.vsize : e.raw_size;
            top = {1'b0, e.start} + {1'b0, span};
            if (addr >= e.start && {1'b0, addr} < top)
            begin
                res.found = 1'b1;
                res.idx = s[EIDX_W-1:0];
                break;
            end
        end
        if (addr < hdr_size && addr < file_len)
        begin
            res.valid = 1'b1;
            res.offset = addr;
        end
        else if (res.found)
        begin
            e = sect_tab[res.idx];
            delta = addr - e.start;
            if (delta < e.raw_size)
            begin
                off = {1'b0, e.raw_off} + {1'b0, delta};
                if (off < {1'b0, file_len})
                begin
                    res.valid = 1'b1;
                    res.offset = off[31:0];
                end
            end
        end
        return res;
    endfunction

    // Mostly image-like layouts with overlaps, some noise, some entries at the top
    // of the address space.
    function automatic request_t make_write(input logic [EIDX_W-1:0] slot);
        request_t req;
        int       sel;
        req.act = ACT_WRITE;
        req.slot = slot;
        req.addr = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            req.ent.start = 32'h1000 * (slot + 1) + $urandom_range(0, 3) * 32'h200;
            req.ent.vsize = $urandom_range(0, 32'h1800);
            req.ent.raw_size = ($urandom_range(0, 3) == 0) ? 32'h0 :
                               $urandom_range(0, 12) * 32'h200;
            req.ent.raw_off = 32'h400 + slot * 32'h1000 + $urandom_range(0, 7) * 32'h200;
            if ($urandom_range(0, 7) == 0)
                req.ent.raw_off = 32'hFFFF_FFFF - $urandom_range(0, 32'h1000);
        end
        else if (sel < 9)
        begin
            req.ent.start = $urandom;
            req.ent.vsize = $urandom;
            req.ent.raw_off = $urandom;
            req.ent.raw_size = $urandom;
        end
        else
        begin
            req.ent.start = 32'hFFFF_FFFF - $urandom_range(0, 32'h2000);
            req.ent.vsize = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            req.ent.raw_off = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            req.ent.raw_size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        return req;
    endfunction

    // Queries mostly land on edges of, or inside, sections that are searched (any slot while the count is zero).
    function automatic logic [31:0] pick_query();
        int          lim;
        sat_entry_t  e;
        logic [31:0] span;
        lim = (int'(sect_count) > SECT_NUM) ? SECT_NUM : int'(sect_count);
        if (lim == 0)
            lim = SECT_NUM;
        e = sect_tab[$urandom_range(0, lim - 1)];
        span = (e.vsize > e.raw_size) ? e.vsize : e.raw_size;
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: return $urandom_range(0, 32'h2000);
            2: return hdr_size + $urandom_range(0, 2) - 32'd1;
            3: return file_len + $urandom_range(0, 2) - 32'd1;
            4: return e.start - 32'd1;
            5: return e.start;
            6: return e.start + e.raw_size - 32'd1;
            7: return e.start + e.raw_size;
            8: return e.start + span - 32'd1;
            9: return e.start + span;
            default: return e.start + $urandom_range(0, span);
        endcase
    endfunction

    function automatic request_t random_request();
        request_t req;
        if ($urandom_range(0, 9) < 3)
        begin
            req = make_write(EIDX_W'($urandom_range(0, SECT_NUM - 1)));
        end
        else
        begin
            req.act = ACT_XLATE;
            req.slot = EIDX_W'($urandom_range(0, SECT_NUM - 1));
            req.ent = {$urandom, $urandom, $urandom, $urandom};
            req.addr = pick_query();
        end
        return req;
    endfunction

    function automatic void add_reg(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t row;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.req = '0;
        row.fixed = 1'b0;
        row.want = '0;
        plan = {plan, row};
    endfunction

    function automatic void add_write(input int slot,
                                      input logic [31:0] st, input logic [31:0] vs,
                                      input logic [31:0] ro, input logic [31:0] rs);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.reg_idx = CFG_HEADERS_SIZE;
        row.reg_val = '0;
        row.req.act = ACT_WRITE;
        row.req.slot = EIDX_W'(slot);
        row.req.ent.start = st;
        row.req.ent.vsize = vs;
        row.req.ent.raw_off = ro;
        row.req.ent.raw_size = rs;
        row.req.addr = $urandom;
        // A write always answers with an all-zero result.
        row.fixed = 1'b1;
        row.want = '0;
        plan = {plan, row};
    endfunction

    function automatic void add_xlate(input logic [31:0] addr, input int fixed,
                                      input int v, input logic [31:0] off,
                                      input int f, input int idx);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.reg_idx = CFG_HEADERS_SIZE;
        row.reg_val = '0;
        row.req.act = ACT_XLATE;
        row.req.slot = EIDX_W'($urandom_range(0, SECT_NUM - 1));
        row.req.ent = {$urandom, $urandom, $urandom, $urandom};
        row.req.addr = addr;
        row.fixed = (fixed != 0);
        row.want = '{valid: (v != 0), offset: off, found: (f != 0), idx: EIDX_W'(idx)};
        plan = {plan, row};
    endfunction

    // Called right after a rising edge; returns in the step of the edge that
    // took the item.
    task automatic send_item(input request_t req, input bit fixed, input outcome_t want);
        outcome_t res;
        start <= 1'b1;
        action <= req.act;
        entry_index <= req.slot;
        section_start <= req.ent.start;
        section_virtual_size <= req.ent.vsize;
        section_raw_offset <= req.ent.raw_off;
        section_raw_size <= req.ent.raw_size;
        query_address <= req.addr;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (req.act == ACT_WRITE)
        begin
            sect_tab[req.slot] = req.ent;
            res = '0;
        end
        else
        begin
            res = translate_address(req.addr);
        end
        pending_results = {pending_results, (fixed ? want : res)};
    endtask

    task automatic maybe_pause(input bit calm);
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_HEADERS_SIZE:  hdr_size = val;
            CFG_FILE_SIZE:     file_len = val;
            CFG_SECTION_COUNT: sect_count = val[CNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            seen = '{valid: offset_valid, offset: file_offset,
                     found: section_found, idx: section_index};
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %h", $time, seen);
                fail_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("offset_valid", 32'(oldest.valid), 32'(seen.valid));
                check_field("file_offset", oldest.offset, seen.offset);
                check_field("section_found", 32'(oldest.found), 32'(seen.found));
                check_field("section_index", 32'(oldest.idx), 32'(seen.idx));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] val;
        logic [6:0]  cnt;
        bit          calm;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HEADERS_SIZE;
        cfg_data = '0;
        start = 1'b0;
        action = ACT_WRITE;
        entry_index = '0;
        section_start = '0;
        section_virtual_size = '0;
        section_raw_offset = '0;
        section_raw_size = '0;
        query_address = '0;
        hdr_size = '0;
        file_len = '0;
        sect_count = '0;
        fail_count = 0;
        idle_run = 0;
        foreach (sect_tab[i])
            sect_tab[i] = '0;

        // Nothing maps straight after reset.
        add_xlate(32'h0000_0000, 1, 0, 0, 0, 0);
        add_xlate(32'hFFFF_FFFF, 1, 0, 0, 0, 0);
        add_write(0, 32'h1000, 32'h2000, 32'h0400, 32'h1000);
        add_write(1, 32'h3000, 32'h0000, 32'h2000, 32'h0800);
        // Starts inside slot 0, so the earlier slot must win.
        add_write(2, 32'h1800, 32'h0800, 32'h5000, 32'h0000);
        add_write(SECT_NUM - 1, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_reg(CFG_HEADERS_SIZE, 32'h0400);
        add_reg(CFG_FILE_SIZE, 32'h1_0000);
        add_reg(CFG_SECTION_COUNT, 32'd3);
        add_xlate(32'h0000, 1, 1, 32'h0000, 0, 0);
        add_xlate(32'h03FF, 1, 1, 32'h03FF, 0, 0);
        add_xlate(32'h0400, 1, 0, 0, 0, 0);
        add_xlate(32'h1000, 1, 1, 32'h0400, 1, 0);
        add_xlate(32'h1FFF, 0, 0, 0, 0, 0);
        // Past the raw data but still inside the virtual span.
        add_xlate(32'h2000, 1, 0, 0, 1, 0);
        add_xlate(32'h2FFF, 1, 0, 0, 1, 0);
        add_xlate(32'h3000, 1, 1, 32'h2000, 1, 1);
        add_xlate(32'h37FF, 0, 0, 0, 0, 0);
        add_xlate(32'h3800, 1, 0, 0, 0, 0);
        // Offset runs into the end of the file.
        add_reg(CFG_FILE_SIZE, 32'h2400);
        add_xlate(32'h3400, 1, 0, 0, 1, 1);
        add_xlate(32'h33FF, 0, 0, 0, 0, 0);
        // Header window bounded by the file size, still reporting the section.
        add_reg(CFG_HEADERS_SIZE, 32'hFFFF_FFFF);
        add_reg(CFG_FILE_SIZE, 32'h1800);
        add_xlate(32'h1000, 1, 1, 32'h1000, 1, 0);
        add_xlate(32'h1800, 0, 0, 0, 0, 0);
        add_xlate(32'h3000, 1, 0, 0, 1, 1);
        add_reg(CFG_SECTION_COUNT, 32'd0);
        add_xlate(32'h3000, 1, 0, 0, 0, 0);
        add_xlate(32'h17FF, 1, 1, 32'h17FF, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                quiesce();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_item(plan[i].req, plan[i].fixed, plan[i].want);
                maybe_pause(1'b0);
            end
        end

        // Fill the whole table while the count is zero, so that no query can
        // ever reach a slot that was never written.
        quiesce();
        for (int s = 0; s < SECT_NUM; s++)
        begin
            send_item(make_write(s[EIDX_W-1:0]), 1'b0, '0);
            maybe_pause(1'b0);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            quiesce();
            case ($urandom_range(0, 3))
                0: val = 32'h0;
                1: val = 32'hFFFF_FFFF;
                2: val = $urandom_range(0, 32'h1000);
                default: val = $urandom;
            endcase
            write_reg(CFG_HEADERS_SIZE, val);
            case ($urandom_range(0, 3))
                0: val = 32'h0;
                1: val = 32'hFFFF_FFFF;
                2: val = $urandom_range(32'h1_0000, 32'h5_0000);
                default: val = $urandom;
            endcase
            write_reg(CFG_FILE_SIZE, val);
            case (ph)
                0: cnt = 7'd64;
                1: cnt = 7'd127;
                2: cnt = 7'd0;
                3: cnt = 7'd1;
                default: cnt = $urandom_range(0, 1) ? 7'($urandom_range(1, 64)) :
                                                      7'($urandom_range(65, 127));
            endcase
            // Bits above the count field are don't-care for the block.
            val = $urandom_range(0, 3) == 0 ? ($urandom & ~32'h7F) : 32'h0;
            write_reg(CFG_SECTION_COUNT, val | 32'(cnt));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, $urandom);
            calm = (ph == RAND_PHASES - 1) || ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
            begin
                send_item(random_request(), 1'b0, '0);
                maybe_pause(calm);
            end
        end

        quiesce();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
